### hw/rtl/lndc_pkg.sv
// Shared types, constants and helpers for the LRU name-to-date cache.
`default_nettype none
package lndc_pkg;

    localparam int ENTRIES_DEF = 20;
    localparam int NAME_BYTES  = 32;
    localparam int KEY_WORDS   = 4;
    localparam int WORD_W      = 64;
    localparam int CNT_W       = 32;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    typedef struct packed {
        t_key              key;
        logic [WORD_W-1:0] date;
        logic              valid;
    } t_entry;

    typedef struct packed {
        logic cmp;     // capture match bits
        logic lookup;  // request may hit at all
        logic upd;     // apply the update step
        logic clr;     // update step invalidates everything
        logic store;   // update step writes a missed name
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    // Bytes past NAME_BYTES never take part in compare or store.
    function automatic logic [WORD_W-1:0] word_mask(input int w);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_W / 8; b++) begin
            if (w * (WORD_W / 8) + b < NAME_BYTES) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/lru_name_date_cache.sv
// Top level of the LRU name-to-date cache: request register, control, counters, result register.
// Fully associative LRU cache kept as a row of ENTRIES slots ordered by recency, slot 0 most
// recent. A request passes through a compare state, which compares the name against every
// slot, and an update state, which shifts the slots and writes the result register. The next
// request is taken in the update state, so a new request can be accepted while the previous one
// updates, as long as the result register is free or being drained. A clear request passes
// through the same states and empties all slots at once; there is no clearing pass after reset.
`default_nettype none
module lru_name_date_cache #(
    parameter int ENTRIES = lndc_pkg::ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic [lndc_pkg::WORD_W-1:0]         i_name_word0,
    input  logic [lndc_pkg::WORD_W-1:0]         i_name_word1,
    input  logic [lndc_pkg::WORD_W-1:0]         i_name_word2,
    input  logic [lndc_pkg::WORD_W-1:0]         i_name_word3,
    input  logic                                i_name_too_long,
    input  logic signed [lndc_pkg::WORD_W-1:0]  i_fill_date,
    input  logic                                i_clear_stats,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [lndc_pkg::WORD_W-1:0]  o_date_out,
    output logic                                o_was_hit,
    output logic [lndc_pkg::CNT_W-1:0]          o_hit_total,
    output logic [lndc_pkg::CNT_W-1:0]          o_miss_total
);
    import lndc_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic              r_cmd;
    t_key              r_key;
    logic              r_too_long;
    logic [WORD_W-1:0] r_fill;
    logic              r_clear_stats;
    logic [CNT_W-1:0]  r_hit_cnt;
    logic [CNT_W-1:0]  r_miss_cnt;
    logic [CNT_W-1:0]  n_hit_cnt;
    logic [CNT_W-1:0]  n_miss_cnt;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_date;
    logic              r_out_hit;

    logic              w_out_free;
    logic              w_ready;
    logic              w_accept;
    logic              w_clear;
    logic              w_hit;
    t_cell_ctl         w_ctl;
    t_entry            w_new;

    t_entry            w_entry   [ENTRIES];
    logic              w_any     [ENTRIES+1];
    logic [WORD_W-1:0] w_hdate   [ENTRIES+1];
    logic [ENTRIES-1:0] w_match_vec;
    logic [ENTRIES-1:0] w_valid_vec;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_accept   = i_valid && w_ready;
    assign w_clear    = (r_cmd == CMD_CLEAR);
    assign w_hit      = w_any[0] && !w_clear;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_CMP;
            ST_CMP:  n_state = ST_UPD;
            ST_UPD: begin
                if (w_out_free) begin
                    n_state = w_accept ? ST_CMP : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ready      = 1'b0;
        w_ctl        = '0;
        w_ctl.lookup = !r_too_long;
        w_ctl.clr    = w_clear;
        case (r_state)
            ST_IDLE: w_ready = 1'b1;
            ST_CMP:  w_ctl.cmp = 1'b1;
            ST_UPD: begin
                w_ready     = w_out_free;
                w_ctl.upd   = w_out_free;
                w_ctl.store = !w_any[0] && !r_too_long && !w_clear;
            end
            default: w_ready = 1'b0;
        endcase
    end

    assign o_stall = !w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd         <= i_cmd;
            r_key[0]      <= i_name_word0 & word_mask(0);
            r_key[1]      <= i_name_word1 & word_mask(1);
            r_key[2]      <= i_name_word2 & word_mask(2);
            r_key[3]      <= i_name_word3 & word_mask(3);
            r_too_long    <= i_name_too_long;
            r_fill        <= i_fill_date;
            r_clear_stats <= i_clear_stats;
        end
    end

    // new most-recent entry: the hit entry moved up, or the missed name
    assign w_new.key   = r_key;
    assign w_new.date  = w_any[0] ? w_hdate[0] : r_fill;
    assign w_new.valid = 1'b1;

    assign w_any[ENTRIES]   = 1'b0;
    assign w_hdate[ENTRIES] = '0;

    for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
        lndc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_req_key   (r_key),
            .i_prev      ((p == 0) ? w_new : w_entry[(p == 0) ? 0 : p-1]),
            .i_any_match (w_any[p+1]),
            .i_hit_date  (w_hdate[p+1]),
            .o_entry     (w_entry[p]),
            .o_match     (w_match_vec[p]),
            .o_any_match (w_any[p]),
            .o_hit_date  (w_hdate[p])
        );
        assign w_valid_vec[p] = w_entry[p].valid;
    end

    always_comb begin
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (w_clear) begin
            if (r_clear_stats) begin
                n_hit_cnt  = '0;
                n_miss_cnt = '0;
            end
        end else if (w_hit) begin
            n_hit_cnt = r_hit_cnt + CNT_W'(1);
        end else begin
            n_miss_cnt = r_miss_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctl.upd) begin
                r_hit_cnt   <= n_hit_cnt;
                r_miss_cnt  <= n_miss_cnt;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.upd) begin
            r_out_date <= w_clear ? '0 : w_new.date;
            r_out_hit  <= w_hit;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_date_out   = r_out_date;
    assign o_was_hit    = r_out_hit;
    assign o_hit_total  = r_hit_cnt;
    assign o_miss_total = r_miss_cnt;

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> $onehot0(w_match_vec))
        else $error("more than one slot matched the request");

    a_long_never_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.upd && w_hit) |-> !r_too_long)
        else $error("overlong name reported as hit");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.upd && w_clear) |=> (w_valid_vec == '0))
        else $error("slots still valid after clear");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.upd && w_hit) |=> (r_hit_cnt == $past(r_hit_cnt) + CNT_W'(1)))
        else $error("hit counter did not advance on hit");

    a_store_fills_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.upd && w_ctl.store) |=> w_valid_vec[0])
        else $error("missed name not written to most recent slot");

endmodule
`default_nettype wire

### hw/rtl/lndc_cell.sv
// One recency slot of the cache: stored entry, match bit and shift link to its neighbor.
`default_nettype none
module lndc_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lndc_pkg::t_cell_ctl               i_ctl,
    input  lndc_pkg::t_key                    i_req_key,
    input  lndc_pkg::t_entry                  i_prev,
    input  logic                              i_any_match,
    input  logic [lndc_pkg::WORD_W-1:0]       i_hit_date,
    output lndc_pkg::t_entry                  o_entry,
    output logic                              o_match,
    output logic                              o_any_match,
    output logic [lndc_pkg::WORD_W-1:0]       o_hit_date
);
    import lndc_pkg::*;

    logic              r_valid;
    logic              r_match;
    t_key              r_key;
    logic [WORD_W-1:0] r_date;
    logic              w_take;

    // slots at or above the hit slot move down one place
    assign o_any_match = r_match | i_any_match;
    assign w_take      = i_ctl.store | o_any_match;
    assign o_hit_date  = i_hit_date | (r_match ? r_date : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_match <= i_ctl.lookup && r_valid && (r_key == i_req_key);
            end
            if (i_ctl.upd) begin
                if (i_ctl.clr) begin
                    r_valid <= 1'b0;
                end else if (w_take) begin
                    r_valid <= i_prev.valid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && !i_ctl.clr && w_take) begin
            r_key  <= i_prev.key;
            r_date <= i_prev.date;
        end
    end

    assign o_entry.key   = r_key;
    assign o_entry.date  = r_date;
    assign o_entry.valid = r_valid;
    assign o_match       = r_match;

endmodule
`default_nettype wire

### bench/tb_lru_name_date_cache.sv
`timescale 1ns / 100ps
// Self-checking bench for lru_name_date_cache: LRU scoreboard, random idling and stall pressure.
module tb_lru_name_date_cache;
    import lndc_pkg::*;

    localparam int SLOTS      = ENTRIES_DEF;
    localparam int POOL_SIZE  = 32;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 10;

    localparam logic signed [WORD_W-1:0] FILL_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [WORD_W-1:0] FILL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        bit                       cmd;
        t_key                     name;
        bit                       too_long;
        logic signed [WORD_W-1:0] fill;
        bit                       clr_stats;
    } t_req;

    typedef struct {
        logic signed [WORD_W-1:0] date;
        logic                     hit;
        logic [CNT_W-1:0]         hits;
        logic [CNT_W-1:0]         misses;
    } t_reply;

    class t_board;
        t_key                     slot_key  [SLOTS];
        logic signed [WORD_W-1:0] slot_date [SLOTS];
        bit                       slot_live [SLOTS];
        int                       slot_age  [SLOTS];
        bit [CNT_W-1:0]           hit_cnt;
        bit [CNT_W-1:0]           miss_cnt;
        t_reply                   due_replies [$];
        int                       errors;

        function new();
            errors   = 0;
            hit_cnt  = '0;
            miss_cnt = '0;
            foreach (slot_live[i]) begin
                slot_live[i] = 1'b0;
                slot_key[i]  = '0;
                slot_date[i] = '0;
            end
            restore_ages();
        endfunction

        // age 0 is most recent
        function void restore_ages();
            foreach (slot_age[i]) slot_age[i] = SLOTS - 1 - i;
        endfunction

        function void promote(int e);
            int r;
            r = slot_age[e];
            foreach (slot_age[i]) if (slot_age[i] < r) slot_age[i]++;
            slot_age[e] = 0;
        endfunction

        function logic [WORD_W-1:0] keep_mask(int w);
            int n;
            n = NAME_BYTES - 8 * w;
            if (n <= 0) return '0;
            if (n >= 8) return '1;
            return (64'd1 << (8 * n)) - 64'd1;
        endfunction

        function void log_request(t_req r);
            t_reply x;
            t_key   k;
            int     found;
            int     victim;
            found  = -1;
            victim = 0;
            if (r.cmd == CMD_CLEAR) begin
                foreach (slot_live[i]) slot_live[i] = 1'b0;
                restore_ages();
                if (r.clr_stats) begin
                    hit_cnt  = '0;
                    miss_cnt = '0;
                end
                x.date = '0;
                x.hit  = 1'b0;
            end else begin
                for (int w = 0; w < KEY_WORDS; w++) k[w] = r.name[w] & keep_mask(w);
                if (!r.too_long) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (found < 0 && slot_live[i] && slot_key[i] == k) found = i;
                    end
                end
                if (found >= 0) begin
                    x.date = slot_date[found];
                    x.hit  = 1'b1;
                    promote(found);
                    hit_cnt++;
                end else begin
                    x.date = r.fill;
                    x.hit  = 1'b0;
                    miss_cnt++;
                    if (!r.too_long) begin
                        foreach (slot_age[i]) if (slot_age[i] == SLOTS - 1) victim = i;
                        slot_key[victim]  = k;
                        slot_date[victim] = r.fill;
                        slot_live[victim] = 1'b1;
                        promote(victim);
                    end
                end
            end
            x.hits   = hit_cnt;
            x.misses = miss_cnt;
            due_replies.push_back(x);
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (due_replies.size() == 0) begin
                errors++;
                $display("%0t: reply with no pending request: date %h hit %b hits %0d misses %0d",
                         $time, got.date, got.hit, got.hits, got.misses);
                return;
            end
            want = due_replies.pop_front();
            if (got.date !== want.date) begin
                errors++;
                $display("%0t: date_out expected %h actual %h", $time, want.date, got.date);
            end
            if (got.hit !== want.hit) begin
                errors++;
                $display("%0t: was_hit expected %b actual %b", $time, want.hit, got.hit);
            end
            if (got.hits !== want.hits) begin
                errors++;
                $display("%0t: hit_total expected %0d actual %0d", $time, want.hits, got.hits);
            end
            if (got.misses !== want.misses) begin
                errors++;
                $display("%0t: miss_total expected %0d actual %0d", $time, want.misses,
                         got.misses);
            end
        endfunction

        function int outstanding();
            return due_replies.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_cmd;
    logic [WORD_W-1:0]        i_name_word0;
    logic [WORD_W-1:0]        i_name_word1;
    logic [WORD_W-1:0]        i_name_word2;
    logic [WORD_W-1:0]        i_name_word3;
    logic                     i_name_too_long;
    logic signed [WORD_W-1:0] i_fill_date;
    logic                     i_clear_stats;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [WORD_W-1:0] o_date_out;
    logic                     o_was_hit;
    logic [CNT_W-1:0]         o_hit_total;
    logic [CNT_W-1:0]         o_miss_total;

    t_board          board;
    t_key            name_pool [POOL_SIZE];
    int              reach    = 12;
    bit              hold_ask = 1'b0;
    bit              no_idle  = 1'b0;

    lru_name_date_cache #(
        .ENTRIES(SLOTS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_name_word0   (i_name_word0),
        .i_name_word1   (i_name_word1),
        .i_name_word2   (i_name_word2),
        .i_name_word3   (i_name_word3),
        .i_name_too_long(i_name_too_long),
        .i_fill_date    (i_fill_date),
        .i_clear_stats  (i_clear_stats),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_date_out     (o_date_out),
        .o_was_hit      (o_was_hit),
        .o_hit_total    (o_hit_total),
        .o_miss_total   (o_miss_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_key fresh_name();
        t_key n;
        int   len;
        int   b;
        n = '0;
        case ($urandom_range(0, 3))
            0: begin
                for (int w = 0; w < KEY_WORDS; w++) n[w] = {$urandom, $urandom};
            end
            1, 2: begin
                len = $urandom_range(1, NAME_BYTES);
                for (b = 0; b < len; b++)
                    n[b / 8][8 * (b % 8) +: 8] = 8'($urandom_range(8'h21, 8'h7E));
                // stray byte past the terminator
                if (len < NAME_BYTES && $urandom_range(0, 1)) begin
                    b = $urandom_range(len + 1 > NAME_BYTES - 1 ? NAME_BYTES - 1 : len + 1,
                                       NAME_BYTES - 1);
                    n[b / 8][8 * (b % 8) +: 8] = 8'($urandom_range(1, 255));
                end
            end
            default: begin
                n = name_pool[$urandom_range(0, POOL_SIZE - 1)];
                n[$urandom_range(0, KEY_WORDS - 1)][$urandom_range(0, WORD_W - 1)] ^= 1'b1;
            end
        endcase
        return n;
    endfunction

    function automatic t_req lookup_of(t_key n, bit tl, logic signed [WORD_W-1:0] d, bit cs);
        t_req r;
        r.cmd       = CMD_LOOKUP;
        r.name      = n;
        r.too_long  = tl;
        r.fill      = d;
        r.clr_stats = cs;
        return r;
    endfunction

    function automatic t_req clear_of(bit cs);
        t_req r;
        r.cmd       = CMD_CLEAR;
        r.name      = fresh_name();
        r.too_long  = 1'($urandom_range(0, 1));
        r.fill      = {$urandom, $urandom};
        r.clr_stats = cs;
        return r;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        int   idx;
        pick = $urandom_range(0, 99);
        r = lookup_of(name_pool[$urandom_range(0, reach - 1)], 1'b0, {$urandom, $urandom},
                      1'($urandom_range(0, 1)));
        if ($urandom_range(0, 15) == 0) r.fill = $urandom_range(0, 1) ? FILL_MIN : FILL_MAX;
        if (pick < 2) begin
            r = clear_of(1'($urandom_range(0, 1)));
        end else if (pick < 7) begin
            r.too_long = 1'b1;
        end else if (pick < 11) begin
            r.name = fresh_name();
        end else if (pick < 14) begin
            idx = $urandom_range(0, POOL_SIZE - 1);
            name_pool[idx] = fresh_name();
            r.name = name_pool[idx];
        end
        return r;
    endfunction

    task automatic send_request(input t_req r);
        i_cmd           <= r.cmd;
        i_name_word0    <= r.name[0];
        i_name_word1    <= r.name[1];
        i_name_word2    <= r.name[2];
        i_name_word3    <= r.name[3];
        i_name_too_long <= r.too_long;
        i_fill_date     <= r.fill;
        i_clear_stats   <= r.clr_stats;
        i_valid         <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.log_request(r);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        t_key zero_n;
        t_key ones_n;
        t_key gap_n;
        t_key twin_n;
        zero_n    = '0;
        ones_n    = '1;
        gap_n     = '0;
        gap_n[0]  = 64'h0000_0000_0042_0041;
        twin_n    = gap_n;
        twin_n[3] = 64'h0100_0000_0000_0000;
        send_request(clear_of(1'b0));
        send_request(clear_of(1'b1));
        send_request(lookup_of(zero_n, 1'b0, FILL_MIN, 1'b1));
        send_request(lookup_of(zero_n, 1'b0, FILL_MAX, 1'b0));
        send_request(lookup_of(ones_n, 1'b0, FILL_MAX, 1'b0));
        send_request(lookup_of(ones_n, 1'b1, 64'sd0, 1'b1));
        send_request(lookup_of(ones_n, 1'b0, -64'sd1, 1'b0));
        send_request(lookup_of(gap_n, 1'b0, 64'sd1, 1'b0));
        send_request(lookup_of(twin_n, 1'b0, 64'sd2, 1'b0));
        send_request(lookup_of(gap_n, 1'b0, 64'sd3, 1'b0));
        send_request(lookup_of(twin_n, 1'b1, 64'sd4, 1'b0));
        send_request(clear_of(1'b0));
        send_request(lookup_of(gap_n, 1'b0, 64'sd5, 1'b0));
        send_request(lookup_of(zero_n, 1'b0, 64'sd6, 1'b1));
        send_request(lookup_of(name_pool[0], 1'b0, {$urandom, $urandom}, 1'b0));
        send_request(lookup_of(name_pool[0], 1'b0, {$urandom, $urandom}, 1'b0));
        send_request(clear_of(1'b1));
        send_request(lookup_of(zero_n, 1'b0, 64'sd7, 1'b0));
    endtask

    initial begin : reply_side
        int     stall_burst;
        int     hold_left;
        t_reply got;
        bit     nxt;
        bit     hold_done;
        stall_burst = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.date   = o_date_out;
                got.hit    = o_was_hit;
                got.hits   = o_hit_total;
                got.misses = o_miss_total;
                board.check_reply(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt = 1'b1;
            end else if (hold_ask && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                nxt = 1'b1;
            end else if (no_idle) begin
                nxt = 1'b0;
            end else if (stall_burst > 0) begin
                stall_burst--;
                nxt = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_burst = $urandom_range(1, 17) - 1;
                nxt = 1'b1;
            end else begin
                nxt = 1'b0;
            end
            i_stall <= nxt;
        end
    end

    initial begin : request_side
        board = new();
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_cmd           <= CMD_LOOKUP;
        i_name_word0    <= '0;
        i_name_word1    <= '0;
        i_name_word2    <= '0;
        i_name_word3    <= '0;
        i_name_too_long <= 1'b0;
        i_fill_date     <= '0;
        i_clear_stats   <= 1'b0;
        foreach (name_pool[i]) name_pool[i] = '0;
        foreach (name_pool[i]) name_pool[i] = fresh_name();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        pause_until_drained();

        reach = 12;
        repeat (500) send_request(random_request());
        pause_until_drained();

        // receiver holds off while requests keep coming
        hold_ask = 1'b1;
        reach = POOL_SIZE;
        repeat (400) send_request(random_request());
        pause_until_drained();

        reach = 24;
        repeat (400) send_request(random_request());

        no_idle = 1'b1;
        reach = SLOTS;
        repeat (225) send_request(random_request());
        i_valid <= 1'b0;

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
